// File: rtl/lmrsw_pkg.sv
// Shared types and constants for the LED matrix row shadow writer.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package lmrsw_pkg;

  localparam int unsigned ROWS      = 8;
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam logic [7:0]  BIT_MSB   = 8'b1000_0000;
  localparam logic [3:0]  ADDR_BASE = 4'h1;

  // Command codes
  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_SET_ROW = 2'd1,
    FN_SET_COL = 2'd2,
    FN_SET_LED = 2'd3
  } lmrsw_func_t;

  // Row update unit operations
  typedef enum logic [1:0] {
    UOP_ZERO = 2'd0,
    UOP_LOAD = 2'd1,
    UOP_PUT  = 2'd2
  } lmrsw_uop_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } lmrsw_state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] value;
    logic       led_on;
  } lmrsw_in_t;

  typedef struct packed {
    logic [3:0] address;
    logic [7:0] data;
    logic       last;
  } lmrsw_out_t;

  // Control from sequencer to row update unit
  typedef struct packed {
    lmrsw_uop_t       op;
    logic [ROW_W-1:0] col;
    logic [7:0]       load;
    logic             bit_val;
  } lmrsw_upd_t;

  // Row store access from sequencer
  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] addr;
    logic [7:0]       wr_data;
  } lmrsw_acc_t;

endpackage

// File: rtl/led_matrix_row_shadow_writer_core.sv
// Top level of the LED matrix row shadow writer.
// Depends on lmrsw_pkg, lmrsw_row_store, lmrsw_row_unit, lmrsw_seq.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Clear and
// set-column requests hold busy while they produce one row write per
// cycle, row addresses 1..8 in order; set-row and set-LED hold busy for
// 1 cycle and produce one write. A request whose target row or column is
// above 7 produces no write and does not raise busy, so the next request
// may follow at once. Each write appears on out_res for exactly one cycle
// with out_valid high, in the cycle after the step that made it, and
// out_res.last marks the final write of a request. The pace is one stored
// row per cycle through the single row update unit and the one store port.
// The receiver cannot hold writes off: it must take every strobed write.
module led_matrix_row_shadow_writer_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lmrsw_pkg::lmrsw_in_t  in_req,
  output logic                  out_valid,
  output lmrsw_pkg::lmrsw_out_t out_res
);
  import lmrsw_pkg::*;

  lmrsw_upd_t upd;
  lmrsw_acc_t acc;
  logic [7:0] old_row;
  logic [7:0] new_row;

  // Sequencer
  lmrsw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .upd       (upd),
    .acc       (acc),
    .new_row   (new_row),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Row image
  lmrsw_row_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rd_data (old_row)
  );

  // Shared row update unit
  lmrsw_row_unit u_unit (
    .upd     (upd),
    .old_row (old_row),
    .new_row (new_row)
  );

endmodule

// File: rtl/lmrsw_row_store.sv
// Eight-entry row byte store, cleared by reset; one write, one read port.
// Depends on lmrsw_pkg.
`timescale 1ns / 1ps

module lmrsw_row_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lmrsw_pkg::lmrsw_acc_t  acc,
  output logic [7:0]             rd_data
);
  import lmrsw_pkg::*;

  logic [7:0] rows_r [ROWS];

  // Row registers, all zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) rows_r[i] <= 8'h00;
    end else if (acc.wr_en) begin
      rows_r[acc.addr] <= acc.wr_data;
    end
  end

  assign rd_data = rows_r[acc.addr];

endmodule

// File: rtl/lmrsw_row_unit.sv
// Shared row update unit: zero, load, or set/clear one column bit.
// Depends on lmrsw_pkg.
`timescale 1ns / 1ps

module lmrsw_row_unit (
  input  lmrsw_pkg::lmrsw_upd_t upd,
  input  logic [7:0]            old_row,
  output logic [7:0]            new_row
);
  import lmrsw_pkg::*;

  logic [7:0] mask;

  assign mask = BIT_MSB >> upd.col;

  always_comb begin
    case (upd.op)
      UOP_ZERO: new_row = 8'h00;
      UOP_LOAD: new_row = upd.load;
      UOP_PUT:  new_row = upd.bit_val ? (old_row | mask) : (old_row & ~mask);
      default:  new_row = old_row;
    endcase
  end

endmodule

// File: rtl/lmrsw_seq.sv
// Command sequencer: steps the row index, drives the update unit and the
// store, and registers one row write per step. Depends on lmrsw_pkg.
`timescale 1ns / 1ps

module lmrsw_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  lmrsw_pkg::lmrsw_in_t    in_req,
  output lmrsw_pkg::lmrsw_upd_t   upd,
  output lmrsw_pkg::lmrsw_acc_t   acc,
  input  logic [7:0]              new_row,
  output logic                    out_valid,
  output lmrsw_pkg::lmrsw_out_t   out_res
);
  import lmrsw_pkg::*;

  lmrsw_state_t     state_r, state_nxt;
  lmrsw_in_t        req_r;
  logic [ROW_W-1:0] idx_r, idx_nxt;
  logic             multi_r, multi_nxt;
  logic             out_valid_r, out_valid_nxt;
  lmrsw_out_t       out_r;

  logic accept, go, last_step, row_ok, col_ok;

  assign busy   = (state_r == ST_RUN);
  assign accept = start && !busy;
  assign row_ok = (in_req.row    <= 8'(ROWS - 1));
  assign col_ok = (in_req.column <= 8'(ROWS - 1));

  // Does the new request cause any write
  always_comb begin
    case (lmrsw_func_t'(in_req.func))
      FN_CLEAR:   go = 1'b1;
      FN_SET_ROW: go = row_ok;
      FN_SET_COL: go = col_ok;
      FN_SET_LED: go = row_ok && col_ok;
      default:    go = 1'b0;
    endcase
  end

  assign last_step = !multi_r || (idx_r == ROW_W'(ROWS - 1));

  // Update unit control for the current step
  always_comb begin
    upd.col     = req_r.column[ROW_W-1:0];
    upd.load    = req_r.value;
    upd.bit_val = req_r.led_on;
    case (lmrsw_func_t'(req_r.func))
      FN_CLEAR:   upd.op = UOP_ZERO;
      FN_SET_ROW: upd.op = UOP_LOAD;
      FN_SET_COL: begin
        upd.op      = UOP_PUT;
        upd.bit_val = req_r.value[~idx_r];
      end
      FN_SET_LED: upd.op = UOP_PUT;
      default:    upd.op = UOP_ZERO;
    endcase
  end

  assign acc.wr_en   = busy;
  assign acc.addr    = idx_r;
  assign acc.wr_data = new_row;

  // Next state
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    multi_nxt     = multi_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && go) begin
          state_nxt = ST_RUN;
          multi_nxt = (lmrsw_func_t'(in_req.func) == FN_CLEAR) ||
                      (lmrsw_func_t'(in_req.func) == FN_SET_COL);
          idx_nxt   = multi_nxt ? '0 : in_req.row[ROW_W-1:0];
        end
      end
      ST_RUN: begin
        out_valid_nxt = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        if (last_step) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      multi_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      multi_r     <= multi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_req;
    if (busy) begin
      out_r.address <= 4'(idx_r) + ADDR_BASE;
      out_r.data    <= new_row;
      out_r.last    <= last_step;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // A clear always starts a run
  a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && lmrsw_func_t'(in_req.func) == FN_CLEAR) |=> busy)
    else $error("clear request did not start a run");

  // The final step of a run returns to idle
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && last_step) |=> !busy)
    else $error("run continued past its final write");

  // A write not marked last is followed by more of the same run
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |-> busy)
    else $error("non-final write with no run in progress");

  // Every write carries a row address in range
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.address != 4'd0 && out_res.address <= 4'(ROWS)))
    else $error("write address out of range");

endmodule

// File: tb/sv/led_matrix_row_shadow_writer_core_tb.sv
// Self-checking testbench for led_matrix_row_shadow_writer_core.
// Depends on lmrsw_pkg and the core RTL; keeps its own 8x8 row image to
// predict every row write and checks each strobed write in order.
`timescale 1ns / 1ps

module led_matrix_row_shadow_writer_core_tb;
  import lmrsw_pkg::*;

  logic       clk    = 1'b0;
  logic       rst_n  = 1'b0;
  logic       start  = 1'b0;
  lmrsw_in_t  in_req = '0;
  logic       busy;
  logic       out_valid;
  lmrsw_out_t out_res;

  // Predicted image and the writes still owed by the block
  logic [7:0] shadow_rows [ROWS];
  lmrsw_out_t pending_writes [$];

  int error_count  = 0;
  int gap_pct      = 36;  // chance in percent of an idle gap before a request

  led_matrix_row_shadow_writer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always #1 clk = ~clk;

  // Print one line per fault, stop printing after a while but keep counting
  task automatic report_error(input string msg);
    if (error_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void queue_row_write(input logic [ROW_W-1:0] r, input bit is_last);
    lmrsw_out_t w;
    w.address = ADDR_BASE + 4'(r);
    w.data    = shadow_rows[r];
    w.last    = is_last;
    pending_writes.push_back(w);
  endfunction

  // Update the image for one request and queue the writes it causes
  function automatic int apply_command(input lmrsw_in_t cmd);
    logic [7:0] mask;
    int         n;
    n    = 0;
    mask = BIT_MSB >> cmd.column[2:0];
    case (lmrsw_func_t'(cmd.func))
      FN_CLEAR: begin
        for (int r = 0; r < ROWS; r++) begin
          shadow_rows[ROW_W'(r)] = 8'h00;
          queue_row_write(ROW_W'(r), r == ROWS - 1);
        end
        n = ROWS;
      end
      FN_SET_ROW: begin
        if (cmd.row < ROWS) begin
          shadow_rows[cmd.row[ROW_W-1:0]] = cmd.value;
          queue_row_write(cmd.row[ROW_W-1:0], 1'b1);
          n = 1;
        end
      end
      FN_SET_COL: begin
        if (cmd.column < ROWS) begin
          // bit 7-r of the pattern lands in row r
          for (int r = 0; r < ROWS; r++) begin
            if (cmd.value[3'(7 - r)])
              shadow_rows[ROW_W'(r)] = shadow_rows[ROW_W'(r)] | mask;
            else
              shadow_rows[ROW_W'(r)] = shadow_rows[ROW_W'(r)] & ~mask;
            queue_row_write(ROW_W'(r), r == ROWS - 1);
          end
          n = ROWS;
        end
      end
      default: begin
        if (cmd.row < ROWS && cmd.column < ROWS) begin
          if (cmd.led_on)
            shadow_rows[cmd.row[ROW_W-1:0]] = shadow_rows[cmd.row[ROW_W-1:0]] | mask;
          else
            shadow_rows[cmd.row[ROW_W-1:0]] = shadow_rows[cmd.row[ROW_W-1:0]] & ~mask;
          queue_row_write(cmd.row[ROW_W-1:0], 1'b1);
          n = 1;
        end
      end
    endcase
    return n;
  endfunction

  function automatic lmrsw_in_t make_cmd(input lmrsw_func_t f, input logic [7:0] r,
                                         input logic [7:0] c, input logic [7:0] v,
                                         input logic on);
    lmrsw_in_t cmd;
    cmd.func   = f;
    cmd.row    = r;
    cmd.column = c;
    cmd.value  = v;
    cmd.led_on = on;
    return cmd;
  endfunction

  // Mostly in-range targets; the rest spread over 8 to 255
  function automatic lmrsw_in_t random_cmd();
    logic [7:0] r;
    logic [7:0] c;
    r = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom_range(255, 8));
    c = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom_range(255, 8));
    return make_cmd(lmrsw_func_t'($urandom_range(3)), r, c, 8'($urandom), 1'($urandom));
  endfunction

  // Issue one request; returns at the edge where it is taken, start left high
  task automatic send_command(input lmrsw_in_t cmd);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      in_req <= lmrsw_in_t'($urandom);
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= cmd;
    do @(posedge clk); while (busy);
    void'(apply_command(cmd));
  endtask

  // Hold off new requests until every owed write has come out
  task automatic wait_writes_done();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Check each strobed write against the oldest prediction
  always @(posedge clk) begin : check_writes
    lmrsw_out_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_writes.size() == 0) begin
        report_error($sformatf("unexpected write addr=%0d data=%02h last=%0b",
                               out_res.address, out_res.data, out_res.last));
      end else begin
        exp_w = pending_writes.pop_front();
        if (out_res.address !== exp_w.address)
          report_error($sformatf("address %0d, want %0d", out_res.address, exp_w.address));
        if (out_res.data !== exp_w.data)
          report_error($sformatf("data %02h, want %02h (addr %0d)",
                                 out_res.data, exp_w.data, exp_w.address));
        if (out_res.last !== exp_w.last)
          report_error($sformatf("last %0b, want %0b (addr %0d)",
                                 out_res.last, exp_w.last, exp_w.address));
      end
    end
  end

  // Clear twice in a row, first with all ones in every field, then all zeros
  task automatic test_clear();
    send_command(make_cmd(FN_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_command(make_cmd(FN_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  // Set-row at both ends, with rows just and far out of range, and a wide column
  task automatic test_set_row();
    send_command(make_cmd(FN_SET_ROW, 8'd0, 8'hFF, 8'hFF, 1'b0));
    send_command(make_cmd(FN_SET_ROW, 8'd7, 8'd0, 8'h81, 1'b1));
    send_command(make_cmd(FN_SET_ROW, 8'd8, 8'd0, 8'h55, 1'b0));
    send_command(make_cmd(FN_SET_ROW, 8'd255, 8'd3, 8'hAA, 1'b1));
    send_command(make_cmd(FN_SET_ROW, 8'd3, 8'd200, 8'h00, 1'b0));
  endtask

  // Set-column on edge, middle and out-of-range columns; row field is ignored
  task automatic test_set_column();
    send_command(make_cmd(FN_SET_COL, 8'd255, 8'd0, 8'hA5, 1'b0));
    send_command(make_cmd(FN_SET_COL, 8'd0, 8'd7, 8'h5A, 1'b1));
    send_command(make_cmd(FN_SET_COL, 8'd2, 8'd8, 8'hFF, 1'b0));
    send_command(make_cmd(FN_SET_COL, 8'd2, 8'd255, 8'hFF, 1'b1));
    send_command(make_cmd(FN_SET_COL, 8'd9, 8'd4, 8'h00, 1'b0));
  endtask

  // Single LEDs: corners on and off, each and both coordinates out, one inside
  task automatic test_set_led();
    send_command(make_cmd(FN_SET_LED, 8'd0, 8'd0, 8'h00, 1'b1));
    send_command(make_cmd(FN_SET_LED, 8'd7, 8'd7, 8'hFF, 1'b1));
    send_command(make_cmd(FN_SET_LED, 8'd0, 8'd0, 8'hFF, 1'b0));
    send_command(make_cmd(FN_SET_LED, 8'd7, 8'd7, 8'h00, 1'b0));
    send_command(make_cmd(FN_SET_LED, 8'd8, 8'd3, 8'h00, 1'b1));
    send_command(make_cmd(FN_SET_LED, 8'd3, 8'd8, 8'h00, 1'b1));
    send_command(make_cmd(FN_SET_LED, 8'd255, 8'd255, 8'hFF, 1'b1));
    send_command(make_cmd(FN_SET_LED, 8'd4, 8'd1, 8'h00, 1'b1));
  endtask

  // Random mix, including requests that write nothing and a run with no gaps
  task automatic test_random_mix(input int n_items);
    int done;
    done = 0;
    while (done < n_items) begin
      gap_pct = (done >= n_items / 3 && done < n_items / 3 + 100) ? 0 : 36;
      if (done == n_items / 2 && $urandom_range(1)) wait_writes_done();
      send_command(random_cmd());
      done++;
    end
  endtask

  initial begin : run_tests
    int spins;
    for (int r = 0; r < ROWS; r++) shadow_rows[ROW_W'(r)] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clear();
    test_set_row();
    test_set_column();
    test_set_led();
    wait_writes_done();
    test_random_mix(360);

    // Drain, with a bound in case writes stop coming
    start <= 1'b0;
    spins = 0;
    while (pending_writes.size() != 0 && spins < 2000) begin
      @(posedge clk);
      spins++;
    end
    if (pending_writes.size() != 0)
      report_error($sformatf("%0d writes never came out", pending_writes.size()));
    repeat (12) @(posedge clk);

    if (error_count == 0) begin
      $display("led_matrix_row_shadow_writer_core: match");
    end else begin
      $display("led_matrix_row_shadow_writer_core: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("led_matrix_row_shadow_writer_core: mismatch");
    $finish;
  end

endmodule

// File: files.f
rtl/lmrsw_pkg.sv
rtl/lmrsw_row_store.sv
rtl/lmrsw_row_unit.sv
rtl/lmrsw_seq.sv
rtl/led_matrix_row_shadow_writer_core.sv
tb/sv/led_matrix_row_shadow_writer_core_tb.sv
